// ----- rtl/cls_pkg.sv -----
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and codes for the compacting list store.
// ----------------------------------------------------------------------------
package cls_pkg;

   localparam int unsigned COMMAND_W = 3;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned INDEX_W   = 6;
   localparam int unsigned COUNT_W   = 7;

   localparam logic [COMMAND_W-1:0] CMD_APPEND       = 3'd0;
   localparam logic [COMMAND_W-1:0] CMD_CONTAINS     = 3'd1;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE_VALUE = 3'd2;
   localparam logic [COMMAND_W-1:0] CMD_REMOVE_INDEX = 3'd3;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR        = 3'd4;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [VALUE_W-1:0]   item_value;
      logic [INDEX_W-1:0]   item_index;
   } req_payload_type;

   typedef struct packed {
      logic               success;
      logic [COUNT_W-1:0] entry_count;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_APPEND,
      DP_CLEAR,
      DP_REJECT,
      DP_FOUND,
      DP_SEARCH_START,
      DP_SCAN,
      DP_SHIFT_FROM_INDEX,
      DP_SHIFT_FROM_HIT,
      DP_SHIFT,
      DP_DELETE_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctl_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic                 full;
      logic                 index_ok;
      logic                 hit;
      logic                 scan_done;
   } dp_status_type;

endpackage

// ----- rtl/cls_datapath.sv -----
// ----------------------------------------------------------------------------
// cls_datapath
// Entry memory, count, scan pointer and response registers.
// ----------------------------------------------------------------------------
module cls_datapath #(
   parameter int unsigned CAPACITY    = 64,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cls_pkg::req_payload_type req_data,
   input  cls_pkg::dp_ctl_type      ctl,
   output cls_pkg::dp_status_type   status,
   output cls_pkg::rsp_payload_type rsp_data
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CW > cls_pkg::INDEX_W) ? CW : cls_pkg::INDEX_W;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [cls_pkg::COMMAND_W-1:0] cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0]        value_ff, value_in;
   logic [cls_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 ptr_ff, ptr_in;
   logic [AW-1:0]                 rd_addr_ff, rd_addr_in;
   logic                          rvalid_ff, rvalid_in;
   logic [VALUE_WIDTH-1:0]        rdata_ff;
   logic                          success_ff, success_in;
   logic [cls_pkg::COUNT_W-1:0]   rsp_count_ff;
   logic                          rsp_load;

   logic                   rd_en;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   issue;
   logic [IW-1:0]          idx_ext;
   logic [IW-1:0]          count_ext;

   assign issue     = (ptr_ff < count_ff);
   assign idx_ext   = IW'(idx_ff);
   assign count_ext = IW'(count_ff);

   always_comb begin
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      rd_addr_in = rd_addr_ff;
      rvalid_in  = rvalid_ff;
      success_in = success_ff;
      rsp_load   = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = value_ff;
      unique case (ctl.op)
         cls_pkg::DP_IDLE: begin
         end
         cls_pkg::DP_LOAD: begin
            cmd_in   = req_data.command;
            value_in = VALUE_WIDTH'(req_data.item_value);
            idx_in   = req_data.item_index;
         end
         cls_pkg::DP_APPEND: begin
            wr_en      = 1'b1;
            count_in   = count_ff + 1'b1;
            success_in = 1'b1;
            rsp_load   = 1'b1;
         end
         cls_pkg::DP_CLEAR: begin
            count_in   = '0;
            success_in = 1'b1;
            rsp_load   = 1'b1;
         end
         cls_pkg::DP_REJECT: begin
            success_in = 1'b0;
            rsp_load   = 1'b1;
         end
         cls_pkg::DP_FOUND: begin
            success_in = 1'b1;
            rsp_load   = 1'b1;
         end
         cls_pkg::DP_SEARCH_START: begin
            ptr_in    = '0;
            rvalid_in = 1'b0;
         end
         cls_pkg::DP_SCAN: begin
            rd_en      = issue;
            rd_addr_in = issue ? ptr_ff[AW-1:0] : rd_addr_ff;
            ptr_in     = issue ? ptr_ff + 1'b1 : ptr_ff;
            rvalid_in  = issue;
         end
         cls_pkg::DP_SHIFT_FROM_INDEX: begin
            ptr_in    = CW'(idx_ext + 1'b1);
            rvalid_in = 1'b0;
         end
         cls_pkg::DP_SHIFT_FROM_HIT: begin
            ptr_in    = CW'(rd_addr_ff) + 1'b1;
            rvalid_in = 1'b0;
         end
         cls_pkg::DP_SHIFT: begin
            rd_en      = issue;
            rd_addr_in = issue ? ptr_ff[AW-1:0] : rd_addr_ff;
            ptr_in     = issue ? ptr_ff + 1'b1 : ptr_ff;
            rvalid_in  = issue;
            wr_en      = rvalid_ff;
            wr_addr    = rd_addr_ff - 1'b1;
            wr_data    = rdata_ff;
         end
         cls_pkg::DP_DELETE_DONE: begin
            count_in   = count_ff - 1'b1;
            success_in = 1'b1;
            rsp_load   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      idx_ff     <= idx_in;
      ptr_ff     <= ptr_in;
      rd_addr_ff <= rd_addr_in;
      success_ff <= success_in;
      if (rsp_load) begin
         rsp_count_ff <= cls_pkg::COUNT_W'(count_in);
      end
   end

   assign status.command   = cmd_ff;
   assign status.full      = (count_ff >= CAP_COUNT);
   assign status.index_ok  = (idx_ext < count_ext);
   assign status.hit       = rvalid_ff && (rdata_ff == value_ff);
   assign status.scan_done = !rvalid_ff && !issue;

   assign rsp_data.success     = success_ff;
   assign rsp_data.entry_count = rsp_count_ff;

endmodule

// ----- rtl/cls_ctrl.sv -----
// ----------------------------------------------------------------------------
// cls_ctrl
// Command sequencer and handshake control for the compacting list store.
// ----------------------------------------------------------------------------
module cls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  cls_pkg::dp_status_type status,
   output cls_pkg::dp_ctl_type    ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_SHIFT,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl.op   = cls_pkg::DP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.op   = cls_pkg::DP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_RESPOND;
            unique case (status.command)
               cls_pkg::CMD_APPEND: begin
                  ctl.op = status.full ? cls_pkg::DP_REJECT : cls_pkg::DP_APPEND;
               end
               cls_pkg::CMD_CONTAINS, cls_pkg::CMD_REMOVE_VALUE: begin
                  ctl.op   = cls_pkg::DP_SEARCH_START;
                  state_in = ST_SEARCH;
               end
               cls_pkg::CMD_REMOVE_INDEX: begin
                  if (status.index_ok) begin
                     ctl.op   = cls_pkg::DP_SHIFT_FROM_INDEX;
                     state_in = ST_SHIFT;
                  end else begin
                     ctl.op = cls_pkg::DP_REJECT;
                  end
               end
               cls_pkg::CMD_CLEAR: begin
                  ctl.op = cls_pkg::DP_CLEAR;
               end
               default: begin
                  ctl.op = cls_pkg::DP_REJECT;
               end
            endcase
         end
         ST_SEARCH: begin
            priority if (status.hit) begin
               if (status.command == cls_pkg::CMD_CONTAINS) begin
                  ctl.op   = cls_pkg::DP_FOUND;
                  state_in = ST_RESPOND;
               end else begin
                  ctl.op   = cls_pkg::DP_SHIFT_FROM_HIT;
                  state_in = ST_SHIFT;
               end
            end else if (status.scan_done) begin
               ctl.op   = cls_pkg::DP_REJECT;
               state_in = ST_RESPOND;
            end else begin
               ctl.op = cls_pkg::DP_SCAN;
            end
         end
         ST_SHIFT: begin
            if (status.scan_done) begin
               ctl.op   = cls_pkg::DP_DELETE_DONE;
               state_in = ST_RESPOND;
            end else begin
               ctl.op = cls_pkg::DP_SHIFT;
            end
         end
         ST_RESPOND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESPOND);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/compacting_list_store.sv -----
// ----------------------------------------------------------------------------
// compacting_list_store
// Dense ordered store of values with append, lookup, delete and clear.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and each gives one response. Append,
// clear, a rejected command and remove at an index at or past the count are
// settled in the dispatch state and go straight to the response. Contains and
// remove by value walk the entry memory one entry per cycle until a hit or
// the end of the list. A delete then moves every later entry down one place
// per cycle. The entry memory has one read port and one write port. Entries
// need no clearing after reset.
module compacting_list_store #(
   parameter int unsigned CAPACITY    = 64,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cls_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cls_pkg::rsp_payload_type rsp_data
);

   cls_pkg::dp_ctl_type    ctl;
   cls_pkg::dp_status_type status;

   cls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   cls_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
